@@ sv/ctsc_pkg.sv @@
// ----------------------------------------------------------------------------
// ctsc_pkg
// Shared constants, codes and tables of the cross-track steering controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ctsc_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int CORDIC_STEPS = 16;

    // request kinds
    localparam logic [1:0] KIND_POSE = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_GOAL = 2'd2;

    // register indexes
    localparam logic [1:0] REG_GAIN   = 2'd0;
    localparam logic [1:0] REG_CRUISE = 2'd1;
    localparam logic [1:0] REG_ATOL   = 2'd2;
    localparam logic [1:0] REG_HTOL   = 2'd3;

    localparam logic [5:0]  GAIN_RST   = 6'd10;
    localparam logic [15:0] CRUISE_RST = 16'd4096;
    localparam logic [11:0] ATOL_RST   = 12'd410;
    localparam logic [7:0]  HTOL_RST   = 8'd4;

    // divide by ten: ceil(2^26 / 10), exact for dividends below TEN_SAT
    localparam logic [25:0]        TEN_RECIP = 26'd6710887;
    localparam int                 TEN_SHIFT = 26;
    localparam logic signed [51:0] TEN_SAT   = 52'sd5242880;

    typedef enum logic [17:0] {
        S_IDLE    = 18'h00001,
        S_MXD     = 18'h00002,
        S_MMM     = 18'h00004,
        S_SQRT_LD = 18'h00008,
        S_SQRT    = 18'h00010,
        S_DIV_LD  = 18'h00020,
        S_DIV     = 18'h00040,
        S_DIV_END = 18'h00080,
        S_CORDIC  = 18'h00100,
        S_TMUL    = 18'h00200,
        S_TRES    = 18'h00400,
        S_DSQ1    = 18'h00800,
        S_DSQ2    = 18'h01000,
        S_DSQ3    = 18'h02000,
        S_DCMP    = 18'h04000,
        S_OUT     = 18'h08000,
        S_TEN     = 18'h10000,
        S_TEN_RES = 18'h20000
    } t_state;

    typedef enum logic [1:0] {
        JOB_SLOPE = 2'd0,
        JOB_ERR   = 2'd1
    } t_job;

    // atan(2^-i) in Q.30
    localparam logic [31:0] ATAN_Q30 [24] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    // rounded to Q.FRAC_BITS
    function automatic logic signed [15:0] cordic_angle(input logic [4:0] idx);
        logic [31:0] sum;
        begin
            sum = ATAN_Q30[idx] + (32'd1 << (29 - FRAC_BITS));
            return 16'(sum >> (30 - FRAC_BITS));
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/cross_track_steering_controller.sv @@
// ----------------------------------------------------------------------------
// cross_track_steering_controller
// Line-following steering controller on one iterative arithmetic sequencer.
// ----------------------------------------------------------------------------
//  channel   signals                                 direction
//  request   i_in_valid/o_in_ready, kind,x,y,heading  in
//  result    o_out_valid/i_out_ready, turn,fwd,stop   out
//  config    psel/penable/pwrite/paddr/pwdata/prdata  APB, in/out
//
//  Goal and pose requests complete on acceptance; a pose that captures a new,
//  non-vertical path also runs the slope divide. An open-path tick runs 24
//  sqrt steps, up to 24 divide steps, CORDIC_STEPS rotations and, if needed, the
//  right-side divide by ten; a done-path tick only checks the goal distance.
//  Divide/sqrt steps share one subtract/compare unit, all products one multiplier.
//  Reset is synchronous; a stalled result is held while the next request runs.
// ----------------------------------------------------------------------------
`default_nettype none

module cross_track_steering_controller
    import ctsc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_kind,
    input  wire logic signed [17:0] i_x_pos,
    input  wire logic signed [17:0] i_y_pos,
    input  wire logic signed [14:0] i_heading,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [19:0]      o_turn_rate,
    output logic [15:0]             o_forward_rate,
    output logic                    o_stopped,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    function automatic logic [18:0] abs19(input logic signed [18:0] v);
        return v[18] ? 19'(-v) : 19'(v);
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [51:0] v);
        if (v > 52'sd524287)       return 20'sh7FFFF;
        else if (v < -52'sd524288) return 20'sh80000;
        else                       return v[19:0];
    endfunction

    t_state r_state;
    t_job   r_job;

    logic [5:0]  r_gain;
    logic [15:0] r_cruise;
    logic [11:0] r_tol;
    logic [7:0]  r_htol;

    logic signed [17:0] r_pose_x, r_pose_y, r_start_x, r_start_y, r_tgt_x, r_tgt_y;
    logic signed [14:0] r_pose_hd;
    logic signed [23:0] r_slope;
    logic               r_captured, r_done;

    logic signed [51:0] r_prod;
    logic signed [25:0] mul_a, mul_b;
    logic signed [56:0] r_acc;
    logic               r_dneg, r_ovf;
    logic [24:0]        r_dsr, r_rem;
    logic [23:0]        r_dlo, r_q;
    logic [4:0]         r_cnt;
    logic [47:0]        r_sv, r_sr, r_sbit;
    logic signed [27:0] r_cx, r_cy;
    logic signed [15:0] r_cz;
    logic signed [25:0] r_err;
    logic signed [19:0] r_turn;
    logic               r_stop;

    logic               r_ovalid;
    logic signed [19:0] r_oturn;
    logic [15:0]        r_ofwd;
    logic               r_ostop;

    logic               in_acc, cfg_wr, out_free;
    logic signed [18:0] in_dx, in_dy, pdx, pdy, ddx, ddy;
    logic [56:0]        acc_mag, div_hi;
    logic [23:0]        dlo_init;
    logic [4:0]         cnt_init;
    logic               div_ovf, div_neg;
    logic [47:0]        sub_a, sub_b;
    logic [48:0]        sub_d;
    logic               sub_ge;
    logic [47:0]        n_sr;
    logic signed [27:0] xsh, ysh;
    logic signed [15:0] ang;
    logic signed [16:0] hd_err;
    logic [16:0]        hd_abs;
    logic               h_lt, h_gt, e_neg, e_zero;
    logic signed [51:0] q_signed;

    assign o_in_ready     = (r_state == S_IDLE);
    assign in_acc         = i_in_valid && o_in_ready;
    assign cfg_wr         = psel && penable && pwrite;
    assign out_free       = !r_ovalid || i_out_ready;
    assign pready         = 1'b1;
    assign o_out_valid    = r_ovalid;
    assign o_turn_rate    = r_oturn;
    assign o_forward_rate = r_ofwd;
    assign o_stopped      = r_ostop;

    always_comb begin
        unique case (paddr[3:2])
            REG_GAIN:   prdata = {26'd0, r_gain};
            REG_CRUISE: prdata = {16'd0, r_cruise};
            REG_ATOL:   prdata = {20'd0, r_tol};
            REG_HTOL:   prdata = {24'd0, r_htol};
        endcase
    end

    assign in_dx = {i_x_pos[17], i_x_pos} - {r_tgt_x[17], r_tgt_x};
    assign in_dy = {r_tgt_y[17], r_tgt_y} - {i_y_pos[17], i_y_pos};
    assign pdx   = {r_pose_x[17], r_pose_x} - {r_start_x[17], r_start_x};
    assign pdy   = {r_pose_y[17], r_pose_y} - {r_start_y[17], r_start_y};
    assign ddx   = {r_pose_x[17], r_pose_x} - {r_tgt_x[17], r_tgt_x};
    assign ddy   = {r_pose_y[17], r_pose_y} - {r_tgt_y[17], r_tgt_y};

    // heading error against the path angle
    assign hd_err = {{2{r_pose_hd[14]}}, r_pose_hd} - {r_cz[15], r_cz};
    assign hd_abs = hd_err[16] ? 17'(-hd_err) : 17'(hd_err);
    assign h_lt   = hd_abs < {9'd0, r_htol};
    assign h_gt   = hd_abs > {9'd0, r_htol};
    assign e_neg  = r_err[25];
    assign e_zero = (r_err == '0);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MXD: begin
                mul_a = {{2{r_slope[23]}}, r_slope};
                mul_b = {{7{pdx[18]}}, pdx};
            end
            S_MMM: begin
                mul_a = {{2{r_slope[23]}}, r_slope};
                mul_b = {{2{r_slope[23]}}, r_slope};
            end
            S_DSQ1: begin
                mul_a = {{7{ddx[18]}}, ddx};
                mul_b = {{7{ddx[18]}}, ddx};
            end
            S_DSQ2: begin
                mul_a = {{7{ddy[18]}}, ddy};
                mul_b = {{7{ddy[18]}}, ddy};
            end
            S_DSQ3: begin
                mul_a = {14'd0, r_tol};
                mul_b = {14'd0, r_tol};
            end
            S_TMUL: begin
                mul_a = h_lt ? r_err : {9'd0, hd_abs};
                mul_b = {20'd0, r_gain};
            end
            S_TEN: begin
                mul_a = {3'd0, r_acc[22:0]};
                mul_b = TEN_RECIP;
            end
            default: ;
        endcase
    end

    // divider load
    assign acc_mag = r_acc[56] ? 57'(-r_acc) : 57'(r_acc);
    assign div_neg = r_acc[56] ^ r_dneg;
    always_comb begin
        case (r_job)
            JOB_SLOPE: begin
                div_hi   = acc_mag >> 23;
                dlo_init = {acc_mag[22:0], 1'b0};
                cnt_init = 5'd23;
            end
            default: begin
                div_hi   = acc_mag >> 24;
                dlo_init = acc_mag[23:0];
                cnt_init = 5'd24;
            end
        endcase
    end
    assign div_ovf = div_hi >= {32'd0, r_dsr};

    // shared subtract/compare unit for divide and square root steps
    always_comb begin
        sub_a = '0;
        sub_b = '0;
        if (r_state == S_DIV) begin
            sub_a = {22'd0, r_rem, r_dlo[23]};
            sub_b = {23'd0, r_dsr};
        end else if (r_state == S_SQRT) begin
            sub_a = r_sv;
            sub_b = r_sr + r_sbit;
        end
    end
    assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge = !sub_d[48];
    assign n_sr   = sub_ge ? ((r_sr >> 1) + r_sbit) : (r_sr >> 1);

    assign xsh = r_cx >>> r_cnt;
    assign ysh = r_cy >>> r_cnt;
    assign ang = cordic_angle(r_cnt);

    assign q_signed = div_neg ? -$signed({28'd0, r_q}) : $signed({28'd0, r_q});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RST;
            r_cruise <= CRUISE_RST;
            r_tol    <= ATOL_RST;
            r_htol   <= HTOL_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_GAIN:   r_gain   <= pwdata[5:0];
                REG_CRUISE: r_cruise <= pwdata[15:0];
                REG_ATOL:   r_tol    <= pwdata[11:0];
                REG_HTOL:   r_htol   <= pwdata[7:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_job      <= JOB_SLOPE;
            r_ovalid   <= 1'b0;
            r_captured <= 1'b0;
            r_done     <= 1'b1;
            r_pose_x   <= '0;
            r_pose_y   <= '0;
            r_pose_hd  <= '0;
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_tgt_x    <= '0;
            r_tgt_y    <= '0;
            r_slope    <= '0;
        end else begin
            if (r_state == S_OUT && out_free) r_ovalid <= 1'b1;
            else if (i_out_ready)             r_ovalid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_kind)
                            KIND_GOAL: begin
                                if (r_done) begin
                                    r_tgt_x <= i_x_pos;
                                    r_tgt_y <= i_y_pos;
                                    r_done  <= 1'b0;
                                end
                            end
                            KIND_POSE: begin
                                if (!r_captured) begin
                                    r_start_x  <= i_x_pos;
                                    r_start_y  <= i_y_pos;
                                    r_captured <= 1'b1;
                                    // vertical path: keep the old slope
                                    if (in_dx != '0) begin
                                        r_acc   <= {{38{in_dy[18]}}, in_dy} << FRAC_BITS;
                                        r_dsr   <= {6'd0, abs19(in_dx)};
                                        r_dneg  <= !in_dx[18];
                                        r_job   <= JOB_SLOPE;
                                        r_state <= S_DIV_LD;
                                    end
                                end
                                r_pose_x  <= i_x_pos;
                                r_pose_y  <= i_y_pos;
                                r_pose_hd <= i_heading;
                                if (abs19(in_dx) < {7'd0, r_tol} &&
                                    abs19({r_tgt_y[17], r_tgt_y} - {i_y_pos[17], i_y_pos})
                                        < {7'd0, r_tol})
                                    r_done <= 1'b1;
                            end
                            KIND_TICK: begin
                                r_state <= r_done ? S_DSQ1 : S_MXD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MXD: r_state <= S_MMM;
                S_MMM: begin
                    r_acc   <= ({{5{r_prod[51]}}, r_prod} << FRAC_BITS)
                             - ({{38{pdy[18]}}, pdy} << (2 * FRAC_BITS));
                    r_state <= S_SQRT_LD;
                end
                S_SQRT_LD: begin
                    r_sv    <= r_prod[47:0] + (48'd1 << (2 * FRAC_BITS));
                    r_sr    <= '0;
                    r_sbit  <= 48'd1 << 46;
                    r_cnt   <= 5'd24;
                    r_dneg  <= 1'b0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (sub_ge) r_sv <= sub_d[47:0];
                    r_sr   <= n_sr;
                    r_sbit <= r_sbit >> 2;
                    r_cnt  <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_dsr   <= n_sr[24:0];
                        r_job   <= JOB_ERR;
                        r_state <= S_DIV_LD;
                    end
                end
                S_DIV_LD: begin
                    r_rem   <= div_hi[24:0];
                    r_dlo   <= dlo_init;
                    r_cnt   <= cnt_init;
                    r_q     <= '0;
                    r_ovf   <= div_ovf;
                    r_state <= div_ovf ? S_DIV_END : S_DIV;
                end
                S_DIV: begin
                    r_rem <= sub_ge ? sub_d[24:0] : sub_a[24:0];
                    r_q   <= {r_q[22:0], sub_ge};
                    r_dlo <= r_dlo << 1;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) r_state <= S_DIV_END;
                end
                S_DIV_END: begin
                    case (r_job)
                        JOB_SLOPE: begin
                            if (r_ovf)
                                r_slope <= div_neg ? 24'sh800000 : 24'sh7FFFFF;
                            else
                                r_slope <= q_signed[23:0];
                            r_state <= S_IDLE;
                        end
                        default: begin
                            if (r_ovf)
                                r_err <= div_neg ? -26'sd16777215 : 26'sd16777215;
                            else
                                r_err <= q_signed[25:0];
                            r_cx    <= 28'sd1 << FRAC_BITS;
                            r_cy    <= {{4{r_slope[23]}}, r_slope};
                            r_cz    <= '0;
                            r_cnt   <= '0;
                            r_state <= S_CORDIC;
                        end
                    endcase
                end
                S_CORDIC: begin
                    if (!r_cy[27] && r_cy != '0) begin
                        r_cx <= r_cx + ysh;
                        r_cy <= r_cy - xsh;
                        r_cz <= r_cz + ang;
                    end else begin
                        r_cx <= r_cx - ysh;
                        r_cy <= r_cy + xsh;
                        r_cz <= r_cz - ang;
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(CORDIC_STEPS - 1)) r_state <= S_TMUL;
                end
                S_TMUL: r_state <= S_TRES;
                S_TRES: begin
                    r_stop <= 1'b0;
                    if (e_zero || (!h_lt && !h_gt)) begin
                        r_turn  <= '0;
                        r_state <= S_OUT;
                    end else if (e_neg) begin
                        r_turn  <= h_lt ? sat20(r_prod) : sat20(-r_prod);
                        r_state <= S_OUT;
                    end else if (h_lt) begin
                        // right side: divide by ten, saturate large products up front
                        if (r_prod >= TEN_SAT) begin
                            r_turn  <= 20'sh7FFFF;
                            r_state <= S_OUT;
                        end else begin
                            r_acc   <= {{5{r_prod[51]}}, r_prod};
                            r_state <= S_TEN;
                        end
                    end else begin
                        r_turn  <= sat20(r_prod);
                        r_state <= S_OUT;
                    end
                end
                S_TEN: r_state <= S_TEN_RES;
                S_TEN_RES: begin
                    r_turn  <= r_prod[TEN_SHIFT + 19:TEN_SHIFT];
                    r_state <= S_OUT;
                end
                S_DSQ1: r_state <= S_DSQ2;
                S_DSQ2: begin
                    r_acc   <= {{5{r_prod[51]}}, r_prod};
                    r_state <= S_DSQ3;
                end
                S_DSQ3: begin
                    r_acc   <= r_acc + {{5{r_prod[51]}}, r_prod};
                    r_state <= S_DCMP;
                end
                S_DCMP: begin
                    if (r_acc < {{5{r_prod[51]}}, r_prod}) begin
                        r_captured <= 1'b0;
                        r_turn     <= '0;
                        r_stop     <= 1'b1;
                        r_state    <= S_OUT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    // hold until the result register frees up
                    if (out_free) begin
                        r_oturn  <= r_turn;
                        r_ofwd   <= r_stop ? 16'd0 : r_cruise;
                        r_ostop  <= r_stop;
                        r_state  <= S_IDLE;
                    end
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_stop_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stopped) |-> (o_turn_rate == '0 && o_forward_rate == '0))
        else $error("stop result carries nonzero rates");

    a_goal_opens_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind == KIND_GOAL && r_done) |=> !r_done)
        else $error("accepted goal did not open the path");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_SQRT) |-> (r_cnt != '0))
        else $error("iteration counter ran out inside a loop");
`endif

endmodule

`default_nettype wire
